/* rtl/pit_pkg.sv */
package pit_pkg;

    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_CH_BASE_ADDR = 256;

    localparam int ADDR_W      = 9;
    localparam int SIZE_W      = 3;
    localparam int WORD_W      = 32;
    localparam int MODE_W      = 2;
    localparam int CTRL_W      = 3;
    localparam int MODCTRL_W   = 2;
    localparam int VIS_CH      = 4;
    localparam int REG_W       = 4;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int IN_PAD_W    = IN_TDATA_W - (ADDR_W + SIZE_W + WORD_W + 1);
    localparam int OUT_PAD_W   = OUT_TDATA_W - (WORD_W + 1 + 2 * VIS_CH);

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [CTRL_W-1:0]    t_ctrl;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [REG_W-1:0]     t_reg_off;

    localparam t_mode MODE_TICK  = 2'd0;
    localparam t_mode MODE_READ  = 2'd1;
    localparam t_mode MODE_WRITE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

    localparam t_reg_off REG_LOAD    = 4'h0;
    localparam t_reg_off REG_CURRENT = 4'h4;
    localparam t_reg_off REG_CONTROL = 4'h8;
    localparam t_reg_off REG_FLAG    = 4'hc;

    localparam int CTRL_EN    = 0;
    localparam int CTRL_IRQEN = 1;
    localparam int CTRL_CHAIN = 2;

    localparam int MOD_FREEZE  = 0;
    localparam int MOD_DISABLE = 1;

    localparam t_ctrl CTRL_MASK_CH0 = 3'b011;
    localparam t_ctrl CTRL_MASK_CHN = 3'b111;

endpackage

/* rtl/periodic_interrupt_timer_chained_top.sv */
// path: an accepted beat enters the input register, then its result beat the result register
// throughput: one tick or register access per cycle unless the output stalls; the chained
//   count-down of all channels and the register decode sit between input and result registers
// reset: i_rst_n synchronous, active low; clears all timer registers and both stage valids,
//   module clock enable comes up set
module periodic_interrupt_timer_chained_top #(
    parameter int NUM_CHANNELS = pit_pkg::DEF_NUM_CHANNELS,
    parameter int CH_BASE_ADDR = pit_pkg::DEF_CH_BASE_ADDR
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_data,     // module_clock_enable
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // address_offset[8:0], access_bytes[11:9], write_data[43:12], halted[44]
    input  logic [pit_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  logic [pit_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data[31:0], access_ok[32], irq_lines[36:33], expired_mask[40:37]
    output logic [pit_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int VIS   = (NUM_CHANNELS < pit_pkg::VIS_CH) ? NUM_CHANNELS : pit_pkg::VIS_CH;
    localparam int REL_W = pit_pkg::ADDR_W + 1;
    localparam logic [REL_W-1:0] BASE_LO = REL_W'(CH_BASE_ADDR);
    localparam logic [REL_W-1:0] BASE_HI = REL_W'(CH_BASE_ADDR + 16 * NUM_CHANNELS);

    // configuration
    logic r_clk_en;

    // input stage
    logic                           r_in_valid;
    pit_pkg::t_mode                 r_in_mode;
    logic [pit_pkg::ADDR_W-1:0]     r_in_addr;
    logic [pit_pkg::SIZE_W-1:0]     r_in_size;
    pit_pkg::t_word                 r_in_wdata;
    logic                           r_in_halted;

    // result stage
    logic                           r_out_valid;
    logic [pit_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [pit_pkg::OUT_TDATA_W-1:0] n_out_data;

    // timer state
    logic [pit_pkg::MODCTRL_W-1:0]  r_mod_ctrl, n_mod_ctrl;
    pit_pkg::t_word                 r_reload [NUM_CHANNELS];
    pit_pkg::t_word                 n_reload [NUM_CHANNELS];
    pit_pkg::t_word                 r_count  [NUM_CHANNELS];
    pit_pkg::t_word                 n_count  [NUM_CHANNELS];
    pit_pkg::t_ctrl                 r_ctrl   [NUM_CHANNELS];
    pit_pkg::t_ctrl                 n_ctrl   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]        r_flag, n_flag;

    logic                           proceed;
    logic                           proc;
    logic                           tick_go;
    logic                           carry;
    logic [NUM_CHANNELS-1:0]        expired;
    logic                           hit_mod;
    logic                           hit_ch;
    logic [REL_W-1:0]               rel;
    logic [CH_W-1:0]                ch_idx;
    pit_pkg::t_reg_off              reg_off;
    pit_pkg::t_ctrl                 new_ctrl;
    pit_pkg::t_word                 rdata;
    logic                           ok;
    logic [pit_pkg::VIS_CH-1:0]     irq_vis;
    logic [pit_pkg::VIS_CH-1:0]     exp_vis;

    assign proceed       = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && proceed;
    assign s_axis_tready = !r_in_valid || proceed;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign tick_go = proc && (r_in_mode == pit_pkg::MODE_TICK) && r_clk_en
                     && !r_mod_ctrl[pit_pkg::MOD_DISABLE]
                     && !(r_mod_ctrl[pit_pkg::MOD_FREEZE] && r_in_halted);

    assign hit_mod = (r_in_addr == '0);
    assign hit_ch  = ({1'b0, r_in_addr} >= BASE_LO) && ({1'b0, r_in_addr} < BASE_HI);
    assign rel     = {1'b0, r_in_addr} - BASE_LO;
    assign ch_idx  = rel[4 +: CH_W];
    assign reg_off = rel[pit_pkg::REG_W-1:0];

    always_comb begin
        n_mod_ctrl = r_mod_ctrl;
        n_reload   = r_reload;
        n_count    = r_count;
        n_ctrl     = r_ctrl;
        n_flag     = r_flag;
        expired    = '0;
        rdata      = '0;
        ok         = 1'b0;
        new_ctrl   = '0;

        // chained count-down: a chained channel takes its lower neighbor's expiry as its tick
        carry = 1'b1;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (!r_ctrl[ch][pit_pkg::CTRL_CHAIN]) begin
                carry = 1'b1;
            end
            if (tick_go && carry && r_ctrl[ch][pit_pkg::CTRL_EN]) begin
                if (r_count[ch] == '0) begin
                    n_count[ch] = r_reload[ch];
                    n_flag[ch]  = 1'b1;
                    expired[ch] = 1'b1;
                end else begin
                    n_count[ch] = r_count[ch] - 1'b1;
                end
            end
            carry = expired[ch];
        end

        if (proc && r_in_mode == pit_pkg::MODE_READ && r_in_size == pit_pkg::SIZE_WORD) begin
            if (hit_mod) begin
                rdata = pit_pkg::WORD_W'(r_mod_ctrl);
                ok    = 1'b1;
            end else if (hit_ch) begin
                ok = 1'b1;
                unique case (reg_off)
                    pit_pkg::REG_LOAD:    rdata = r_reload[ch_idx];
                    pit_pkg::REG_CURRENT: rdata = r_count[ch_idx];
                    pit_pkg::REG_CONTROL: rdata = pit_pkg::WORD_W'(r_ctrl[ch_idx]);
                    pit_pkg::REG_FLAG:    rdata = pit_pkg::WORD_W'(r_flag[ch_idx]);
                    default:              ok    = 1'b0;
                endcase
            end
        end

        if (proc && r_in_mode == pit_pkg::MODE_WRITE && r_in_size == pit_pkg::SIZE_WORD) begin
            if (hit_mod) begin
                n_mod_ctrl = r_in_wdata[pit_pkg::MODCTRL_W-1:0];
                ok         = 1'b1;
            end else if (hit_ch) begin
                unique case (reg_off)
                    pit_pkg::REG_LOAD: begin
                        n_reload[ch_idx] = r_in_wdata;
                        ok               = 1'b1;
                    end
                    pit_pkg::REG_CONTROL: begin
                        // channel 0 has no lower neighbor to chain from
                        new_ctrl = r_in_wdata[pit_pkg::CTRL_W-1:0]
                                   & ((ch_idx == '0) ? pit_pkg::CTRL_MASK_CH0
                                                     : pit_pkg::CTRL_MASK_CHN);
                        n_ctrl[ch_idx] = new_ctrl;
                        if (!r_ctrl[ch_idx][pit_pkg::CTRL_EN] && new_ctrl[pit_pkg::CTRL_EN]) begin
                            n_count[ch_idx] = r_reload[ch_idx];
                        end
                        ok = 1'b1;
                    end
                    pit_pkg::REG_FLAG: begin
                        if (r_in_wdata[0]) begin
                            n_flag[ch_idx] = 1'b0;
                        end
                        ok = 1'b1;
                    end
                    default: ok = 1'b0;
                endcase
            end
        end

        irq_vis = '0;
        exp_vis = '0;
        for (int ch = 0; ch < VIS; ch++) begin
            irq_vis[ch] = n_flag[ch] && n_ctrl[ch][pit_pkg::CTRL_IRQEN];
            exp_vis[ch] = expired[ch];
        end

        n_out_data = {{pit_pkg::OUT_PAD_W{1'b0}}, exp_vis, irq_vis, ok, rdata};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clk_en <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode   <= s_axis_tuser;
            r_in_addr   <= s_axis_tdata[pit_pkg::ADDR_W-1:0];
            r_in_size   <= s_axis_tdata[pit_pkg::ADDR_W +: pit_pkg::SIZE_W];
            r_in_wdata  <= s_axis_tdata[pit_pkg::ADDR_W + pit_pkg::SIZE_W +: pit_pkg::WORD_W];
            r_in_halted <= s_axis_tdata[pit_pkg::ADDR_W + pit_pkg::SIZE_W + pit_pkg::WORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_ctrl <= '0;
            r_flag     <= '0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r_reload[ch] <= '0;
                r_count[ch]  <= '0;
                r_ctrl[ch]   <= '0;
            end
        end else begin
            r_mod_ctrl <= n_mod_ctrl;
            r_flag     <= n_flag;
            r_reload   <= n_reload;
            r_count    <= n_count;
            r_ctrl     <= n_ctrl;
        end
    end

`ifndef SYNTHESIS
    // a held beat in the input stage is not dropped while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proceed |=> r_in_valid)
        else $error("input beat lost during result stall");

    // a tick while the module is disabled leaves the channel 0 counter alone
    a_disabled_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_in_mode == pit_pkg::MODE_TICK) && r_mod_ctrl[pit_pkg::MOD_DISABLE]
        |=> $stable(r_count[0]))
        else $error("counter moved while module disabled");

    // a pending result that reports a channel 0 expiry still sees its flag set
    a_expiry_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[pit_pkg::WORD_W + 1 + pit_pkg::VIS_CH] |-> r_flag[0])
        else $error("expiry reported without flag");
`endif

endmodule
